// File: design/ffa_pkg.sv
package ffa_pkg;

  localparam int MAX_SEGMENTS = 32;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int DATA_W       = 16;
  localparam int STATUS_W     = 3;
  localparam int CFG_IDX_W    = 1;

  localparam logic [DATA_W-1:0] HEAP_BASE_RST = 16'd1000;
  localparam logic [DATA_W-1:0] HEAP_SIZE_RST = 16'd24000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE = 1'b0,
    REG_HEAP_SIZE = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_code_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_RANGE   = 3'd2,
    ST_NOBLOCK = 3'd3,
    ST_ZERO    = 3'd4
  } status_t;

  typedef struct packed {
    logic [DATA_W-1:0] start;
    logic [DATA_W-1:0] len;
    logic              used;
  } seg_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_INIT,
    OP_SCAN0,
    OP_SCAN,
    OP_SHUP0,
    OP_SHUP,
    OP_SPLIT,
    OP_MARK,
    OP_MERGE,
    OP_FREE_WR,
    OP_SHDN,
    OP_SHRINK,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t     op;
    status_t code;
    logic    give_addr;
  } ctl_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic table_ready;
    logic is_alloc;
    logic size_zero;
    logic range_bad;
    logic at_end;
    logic hit;
    logic exact;
    logic table_full;
    logic up_empty;
    logic up_last;
    logic rem_zero;
    logic dn_end;
    logic out_free;
  } dp_stat_t;

endpackage

// File: design/ffa_in_if.sv
interface ffa_in_if;
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic [ffa_pkg::DATA_W-1:0]    request_size;
  logic [ffa_pkg::DATA_W-1:0]    address;

  modport source (output valid, command, request_size, address, input ready);
  modport sink   (input valid, command, request_size, address, output ready);
endinterface

// File: design/ffa_out_if.sv
interface ffa_out_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::STATUS_W-1:0]  status;
  logic [ffa_pkg::DATA_W-1:0]    block_address;

  modport source (output valid, status, block_address, input ready);
  modport sink   (input valid, status, block_address, output ready);
endinterface

// File: design/ffa_cfg_if.sv
interface ffa_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ffa_pkg::CFG_IDX_W-1:0] index;
  logic [ffa_pkg::DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: design/ffa_ram.sv
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/ffa_datapath.sv
module ffa_datapath (
  input  logic              clk,
  input  logic              rst_n,
  ffa_in_if.sink            in_chan,
  ffa_out_if.source         out_chan,
  ffa_cfg_if.sink           cfg_chan,
  input  ffa_pkg::ctl_cmd_t cmd,
  output ffa_pkg::dp_stat_t st
);

  localparam int IW = ffa_pkg::IDX_W;
  localparam int CW = ffa_pkg::CNT_W;
  localparam int DW = ffa_pkg::DATA_W;

  // configuration
  logic [DW-1:0] base_r;
  logic [DW-1:0] size_r;
  logic [DW:0]   room;
  logic [DW-1:0] heap_len;

  // latched request
  ffa_pkg::cmd_code_t cmd_r;
  logic [DW-1:0]      req_size_r;
  logic [DW-1:0]      req_addr_r;

  // table control
  logic          ready_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] j_r;
  logic [CW-1:0] hidx_r;
  ffa_pkg::seg_t hit_r;
  ffa_pkg::seg_t prev_r;

  // merge result
  logic [CW-1:0] dst_r;
  logic [DW-1:0] dstart_r;
  logic [DW-1:0] mlen_r;
  logic [1:0]    rem_r;

  // output register
  logic                         out_valid_r;
  logic [ffa_pkg::STATUS_W-1:0] out_status_r;
  logic [DW-1:0]                out_addr_r;

  // table memory
  logic          we;
  logic [IW-1:0] waddr;
  logic [IW-1:0] raddr;
  ffa_pkg::seg_t wdata;
  ffa_pkg::seg_t rdata;
  logic [$bits(ffa_pkg::seg_t)-1:0] rdata_raw;

  logic          in_fire;
  logic          result_load;
  logic [CW-1:0] k_plus;
  logic [CW-1:0] j_plus;
  logic [CW-1:0] j_minus;
  logic [CW-1:0] count_m1;
  logic [CW-1:0] hidx_plus;
  logic [CW-1:0] src_first;
  logic          prev_free;
  logic          next_free;
  logic [DW-1:0] mlen;

  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= ffa_pkg::HEAP_BASE_RST;
      size_r <= ffa_pkg::HEAP_SIZE_RST;
    end else if (cfg_chan.valid) begin
      unique case (ffa_pkg::reg_idx_t'(cfg_chan.index))
        ffa_pkg::REG_HEAP_BASE: base_r <= cfg_chan.data;
        ffa_pkg::REG_HEAP_SIZE: size_r <= cfg_chan.data;
      endcase
    end
  end

  // heap never runs past the top of the address space
  assign room     = {1'b1, {DW{1'b0}}} - {1'b0, base_r};
  assign heap_len = ({1'b0, size_r} < room) ? size_r : room[DW-1:0];

  assign in_chan.ready = (cmd.op == ffa_pkg::OP_ACCEPT);
  assign in_fire       = in_chan.ready && in_chan.valid;
  assign result_load   = (cmd.op == ffa_pkg::OP_RESULT) && st.out_free;

  assign k_plus    = k_r + CW'(1);
  assign j_plus    = j_r + CW'(1);
  assign j_minus   = j_r - CW'(1);
  assign count_m1  = count_r - CW'(1);
  assign hidx_plus = hidx_r + CW'(1);
  assign src_first = dst_r + CW'(1) + CW'(rem_r);

  assign prev_free = (hidx_r != '0) && !prev_r.used;
  assign next_free = (k_r < count_r) && !rdata.used;
  assign mlen      = hit_r.len + (prev_free ? prev_r.len : '0) + (next_free ? rdata.len : '0);

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    unique case (cmd.op)
      ffa_pkg::OP_INIT: begin
        we    = 1'b1;
        wdata = '{start: base_r, len: heap_len, used: 1'b0};
      end
      ffa_pkg::OP_SCAN: raddr = k_plus[IW-1:0];
      ffa_pkg::OP_SHUP0: raddr = count_m1[IW-1:0];
      ffa_pkg::OP_SHUP: begin
        we    = 1'b1;
        waddr = j_plus[IW-1:0];
        wdata = rdata;
        raddr = j_minus[IW-1:0];
      end
      ffa_pkg::OP_SPLIT: begin
        we    = 1'b1;
        waddr = hidx_plus[IW-1:0];
        wdata = '{start: hit_r.start + req_size_r, len: hit_r.len - req_size_r, used: 1'b0};
      end
      ffa_pkg::OP_MARK: begin
        we    = 1'b1;
        waddr = hidx_r[IW-1:0];
        wdata = '{start: hit_r.start, len: req_size_r, used: 1'b1};
      end
      ffa_pkg::OP_FREE_WR: begin
        we    = 1'b1;
        waddr = dst_r[IW-1:0];
        wdata = '{start: dstart_r, len: mlen_r, used: 1'b0};
        raddr = src_first[IW-1:0];
      end
      ffa_pkg::OP_SHDN: begin
        we    = 1'b1;
        waddr = IW'(j_r - CW'(rem_r));
        wdata = rdata;
        raddr = j_plus[IW-1:0];
      end
      default: ;
    endcase
  end

  ffa_ram #(
    .WIDTH ($bits(ffa_pkg::seg_t)),
    .DEPTH (ffa_pkg::MAX_SEGMENTS)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata_raw)
  );

  assign rdata = ffa_pkg::seg_t'(rdata_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ready_r     <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        ffa_pkg::OP_INIT: begin
          ready_r <= 1'b1;
          count_r <= CW'(1);
        end
        ffa_pkg::OP_SPLIT:  count_r <= count_r + CW'(1);
        ffa_pkg::OP_SHRINK: count_r <= count_r - CW'(rem_r);
        default: ;
      endcase
      if (result_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r      <= ffa_pkg::cmd_code_t'(in_chan.command);
      req_size_r <= in_chan.request_size;
      req_addr_r <= in_chan.address;
    end
    unique case (cmd.op)
      ffa_pkg::OP_SCAN0: k_r <= '0;
      ffa_pkg::OP_SCAN: begin
        // hit_r trails the read by one entry, prev_r by two
        k_r    <= k_plus;
        hit_r  <= rdata;
        prev_r <= hit_r;
        hidx_r <= k_r;
      end
      ffa_pkg::OP_SHUP0: j_r <= count_m1;
      ffa_pkg::OP_SHUP:  j_r <= j_minus;
      ffa_pkg::OP_MERGE: begin
        dst_r    <= prev_free ? hidx_r - CW'(1) : hidx_r;
        dstart_r <= prev_free ? prev_r.start : hit_r.start;
        mlen_r   <= mlen;
        rem_r    <= {1'b0, prev_free} + {1'b0, next_free};
      end
      ffa_pkg::OP_FREE_WR: j_r <= src_first;
      ffa_pkg::OP_SHDN:    j_r <= j_plus;
      default: ;
    endcase
    if (result_load) begin
      out_status_r <= cmd.code;
      out_addr_r   <= cmd.give_addr ? hit_r.start : '0;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.block_address = out_addr_r;

  assign st.in_fire     = in_fire;
  assign st.table_ready = ready_r;
  assign st.is_alloc    = (cmd_r == ffa_pkg::CMD_ALLOC);
  assign st.size_zero   = (req_size_r == '0);
  assign st.range_bad   = (heap_len == '0) || (req_addr_r < base_r) ||
                          ((req_addr_r - base_r) >= heap_len);
  assign st.at_end      = (k_r >= count_r);
  assign st.hit         = st.is_alloc ? (!rdata.used && (rdata.len >= req_size_r))
                                      : (rdata.used && (rdata.start == req_addr_r));
  assign st.exact       = (hit_r.len == req_size_r);
  assign st.table_full  = (count_r == CW'(ffa_pkg::MAX_SEGMENTS));
  assign st.up_empty    = (count_r == hidx_plus);
  assign st.up_last     = (j_r == hidx_plus);
  assign st.rem_zero    = (rem_r == '0);
  assign st.dn_end      = (j_r >= count_r);
  assign st.out_free    = !out_valid_r || out_chan.ready;

endmodule

// File: design/ffa_ctrl.sv
module ffa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  ffa_pkg::dp_stat_t st,
  output ffa_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_DISPATCH,
    S_SCAN0,
    S_SCAN,
    S_ALLOC_CHK,
    S_SHUP0,
    S_SHUP,
    S_SPLIT,
    S_MARK,
    S_FREE_MRG,
    S_FREE_WR,
    S_SHDN,
    S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  ffa_pkg::status_t code_r, code_nxt;
  logic             give_addr_r, give_addr_nxt;
  ffa_pkg::op_t     op;

  always_comb begin
    state_nxt     = state_r;
    code_nxt      = code_r;
    give_addr_nxt = give_addr_r;
    op            = ffa_pkg::OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        op = ffa_pkg::OP_ACCEPT;
        if (st.in_fire) begin
          state_nxt     = st.table_ready ? S_DISPATCH : S_INIT;
          give_addr_nxt = 1'b0;
        end
      end
      S_INIT: begin
        op        = ffa_pkg::OP_INIT;
        state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (st.is_alloc && st.size_zero) begin
          code_nxt  = ffa_pkg::ST_ZERO;
          state_nxt = S_DONE;
        end else if (!st.is_alloc && st.range_bad) begin
          code_nxt  = ffa_pkg::ST_RANGE;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN0;
        end
      end
      S_SCAN0: begin
        op        = ffa_pkg::OP_SCAN0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (st.at_end) begin
          code_nxt  = st.is_alloc ? ffa_pkg::ST_FULL : ffa_pkg::ST_NOBLOCK;
          state_nxt = S_DONE;
        end else begin
          op = ffa_pkg::OP_SCAN;
          if (st.hit) begin
            state_nxt = st.is_alloc ? S_ALLOC_CHK : S_FREE_MRG;
          end
        end
      end
      S_ALLOC_CHK: begin
        priority if (st.exact) begin
          state_nxt = S_MARK;
        end else if (st.table_full) begin
          code_nxt  = ffa_pkg::ST_FULL;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SHUP0;
        end
      end
      S_SHUP0: begin
        op        = ffa_pkg::OP_SHUP0;
        state_nxt = st.up_empty ? S_SPLIT : S_SHUP;
      end
      S_SHUP: begin
        op = ffa_pkg::OP_SHUP;
        if (st.up_last) begin
          state_nxt = S_SPLIT;
        end
      end
      S_SPLIT: begin
        op        = ffa_pkg::OP_SPLIT;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        op            = ffa_pkg::OP_MARK;
        code_nxt      = ffa_pkg::ST_OK;
        give_addr_nxt = 1'b1;
        state_nxt     = S_DONE;
      end
      S_FREE_MRG: begin
        op        = ffa_pkg::OP_MERGE;
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        op       = ffa_pkg::OP_FREE_WR;
        code_nxt = ffa_pkg::ST_OK;
        // nothing merged: no entries to close up
        state_nxt = st.rem_zero ? S_DONE : S_SHDN;
      end
      S_SHDN: begin
        if (st.dn_end) begin
          op        = ffa_pkg::OP_SHRINK;
          state_nxt = S_DONE;
        end else begin
          op = ffa_pkg::OP_SHDN;
        end
      end
      S_DONE: begin
        op = ffa_pkg::OP_RESULT;
        if (st.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      code_r      <= ffa_pkg::ST_OK;
      give_addr_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      code_r      <= code_nxt;
      give_addr_r <= give_addr_nxt;
    end
  end

  assign cmd = '{op: op, code: code_r, give_addr: give_addr_r};

endmodule

// File: design/first_fit_heap_allocator_unit.sv
// Zero-size alloc and out-of-range free requests are answered without a table scan.
// One request at a time; the next is taken the cycle after the result is registered.
// The segment table has separate read and write ports; one entry is scanned or moved per cycle.
// Synchronous active-low reset restores heap_base/heap_size; the table is rebuilt
// as one free segment on the first request after reset.
module first_fit_heap_allocator_unit (
  input  logic      clk,
  input  logic      rst_n,
  ffa_in_if.sink    in_chan,
  ffa_out_if.source out_chan,
  ffa_cfg_if.sink   cfg_chan
);

  ffa_pkg::ctl_cmd_t cmd;
  ffa_pkg::dp_stat_t st;

  ffa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  ffa_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan),
    .cmd      (cmd),
    .st       (st)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    st.in_fire |=> !in_chan.ready)
    else $error("request accepted while previous one still in work");

  a_split_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == ffa_pkg::OP_SPLIT) |-> !st.table_full)
    else $error("segment split with full table");

  a_addr_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && (out_chan.status != ffa_pkg::ST_OK)) |-> (out_chan.block_address == '0))
    else $error("nonzero block address on failed request");

endmodule
